// ===== design/assert_macros.svh =====
// Assertion macros shared by the keyboard event differ modules.
// Each macro expects a clock named clk and an active-low reset named arst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication or plain invariant.
`define HKD_ASSERT(name, prop, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Consequence in the cycle after the antecedent.
`define HKD_ASSERT_NEXT(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== design/hkd_pkg.sv =====
// Shared types and constants for the keyboard report event differ.
// No dependencies; used by hkd_lane, hkd_emit and the top level.
`default_nettype none

package hkd_pkg;

	localparam int IN_SLOTS   = 6;
	localparam int MAX_EVENTS = 12;
	localparam int CNT_W      = 4;
	localparam int KEY_W      = 8;
	localparam int FLAG_W     = 4;
	localparam int CFG_W      = 16;

	localparam logic [KEY_W-1:0] CAPS_CODE    = 8'h39;
	localparam logic [CFG_W-1:0] RST_DELAY    = 16'd500;
	localparam logic [CFG_W-1:0] RST_INTERVAL = 16'd50;
	localparam logic             MODE_TICK    = 1'b1;

	typedef enum logic [1:0] {
		EV_DOWN   = 2'd0,
		EV_UP     = 2'd1,
		EV_REPEAT = 2'd2
	} event_kind_t;

	typedef enum logic {
		CFG_START_DELAY = 1'b0,
		CFG_INTERVAL    = 1'b1
	} cfg_reg_t;

	typedef struct packed {
		logic down;
		logic up;
	} lane_hit_t;

endpackage

`default_nettype wire

// ===== design/hkd_lane.sv =====
// One slot lane: decides whether this slot gives a down and/or an up event.
// Depends on hkd_pkg for lane_hit_t and the key width.
`default_nettype none

module hkd_lane #(
	parameter int KEY_SLOTS = 6
) (
	input  logic [hkd_pkg::KEY_W-1:0]                cur_code,
	input  logic [hkd_pkg::KEY_W-1:0]                prev_code,
	input  logic [KEY_SLOTS-1:0][hkd_pkg::KEY_W-1:0] cur_keys,
	input  logic [KEY_SLOTS-1:0][hkd_pkg::KEY_W-1:0] prev_keys,
	output hkd_pkg::lane_hit_t                       hit
);

	logic in_prev;
	logic in_cur;

	always_comb begin
		in_prev = 1'b0;
		in_cur  = 1'b0;
		for (int i = 0; i < KEY_SLOTS; i++) begin
			if (prev_keys[i] == cur_code) in_prev = 1'b1;
			if (cur_keys[i] == prev_code) in_cur = 1'b1;
		end
		hit.down = (cur_code != '0) && !in_prev;
		hit.up   = (prev_code != '0) && !in_cur;
	end

endmodule

`default_nettype wire

// ===== design/hkd_emit.sv =====
// Event sequencer: holds the pending event set of one item and drains it in slot order into
// an output register, one beat per unstalled cycle. Depends on hkd_pkg, assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module hkd_emit #(
	parameter int KEY_SLOTS = 6
) (
	input  logic                                       clk,
	input  logic                                       arst_n,
	input  logic                                       load,
	input  logic [2*KEY_SLOTS-1:0]                     load_ev,
	input  logic [2*KEY_SLOTS-1:0][hkd_pkg::KEY_W-1:0] load_codes,
	input  logic [hkd_pkg::FLAG_W-1:0]                 load_flags,
	input  logic                                       load_repeat,
	output logic                                       can_load,
	output logic                                       out_valid,
	input  logic                                       out_ready,
	output logic [1:0]                                 out_kind,
	output logic [hkd_pkg::KEY_W-1:0]                  out_code,
	output logic [hkd_pkg::FLAG_W-1:0]                 out_flags,
	output logic                                       out_last
);

	localparam int EV_N  = 2 * KEY_SLOTS;
	localparam int SEL_W = $clog2(EV_N);

	logic [EV_N-1:0]                     pend_q;
	logic [EV_N-1:0][hkd_pkg::KEY_W-1:0] codes_q;
	logic [hkd_pkg::FLAG_W-1:0]          flags_q;
	logic                                rep_q;
	logic [hkd_pkg::CNT_W-1:0]           cnt_q;

	logic                        out_valid_q;
	hkd_pkg::event_kind_t        kind_q;
	logic [hkd_pkg::KEY_W-1:0]   code_q;
	logic [hkd_pkg::FLAG_W-1:0]  oflags_q;
	logic                        last_q;

	logic [SEL_W-1:0] sel_idx;
	logic             found;
	logic [EV_N-1:0]  rest;
	logic             sel_last;
	logic             busy;
	logic             adv;

	// Pick the lowest pending event: even bits are downs, odd bits ups of a slot.
	always_comb begin
		sel_idx = '0;
		found   = 1'b0;
		for (int i = 0; i < EV_N; i++) begin
			if (pend_q[i] && !found) begin
				sel_idx = SEL_W'(i);
				found   = 1'b1;
			end
		end
		rest     = pend_q & ~(EV_N'(1) << sel_idx);
		// Drop whatever is left once the result limit is reached.
		sel_last = (rest == '0) || (cnt_q == hkd_pkg::CNT_W'(hkd_pkg::MAX_EVENTS - 1));
		busy     = |pend_q;
		adv      = busy && (!out_valid_q || out_ready);
		can_load = !busy || (adv && sel_last);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
			cnt_q  <= '0;
		end else if (load) begin
			pend_q <= load_ev;
			cnt_q  <= '0;
		end else if (adv) begin
			pend_q <= sel_last ? '0 : rest;
			cnt_q  <= cnt_q + hkd_pkg::CNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			codes_q <= load_codes;
			flags_q <= load_flags;
			rep_q   <= load_repeat;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			if (rep_q) kind_q <= hkd_pkg::EV_REPEAT;
			else if (sel_idx[0]) kind_q <= hkd_pkg::EV_UP;
			else kind_q <= hkd_pkg::EV_DOWN;
			code_q   <= codes_q[sel_idx];
			oflags_q <= flags_q;
			last_q   <= sel_last;
		end
	end

	assign out_valid = out_valid_q;
	assign out_kind  = kind_q;
	assign out_code  = code_q;
	assign out_flags = oflags_q;
	assign out_last  = last_q;

	`HKD_ASSERT(a_cnt_limit, !busy || (cnt_q < hkd_pkg::CNT_W'(hkd_pkg::MAX_EVENTS)), "event count past limit")
	`HKD_ASSERT(a_load_free, !load || can_load, "load while sequencer still holds events")
	`HKD_ASSERT_NEXT(a_drain_done, adv && sel_last && !load, !busy, "events left after last beat")

endmodule

`default_nettype wire

// ===== design/hid_keyboard_report_event_differ_unit.sv =====
// Top level of the keyboard report event differ: report/tick state, slot lanes,
// merge of lane results and the event sequencer. Depends on hkd_pkg, hkd_lane, hkd_emit.
//
//  channel | signals                                   | dir | handshake
//  --------+-------------------------------------------+-----+-----------------
//  input   | mode, modifier_byte, key_slot_0..5         | in  | in_valid/in_ready
//  result  | event_kind, key_code, modifier_flags, last | out | out_valid/out_ready
//  config  | cfg_index, cfg_data                       | in  | cfg_we, no wait
//
// An item is evaluated in the cycle it is accepted; its events then leave one per
// cycle from the sequencer while the output is not stalled: a report gives up to 12,
// a tick at most one repeat, and an item without events gives no result.
// The next item is taken in the cycle the sequencer hands over its final event.
// Output stalls hold the sequencer; the output register lets one more item in meanwhile.
// Reset restores the power-up register values and clears all key and timing state.
`default_nettype none
`include "assert_macros.svh"

module hid_keyboard_report_event_differ_unit #(
	parameter int KEY_SLOTS = 6
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic       mode,
	input  logic [7:0] modifier_byte,
	input  logic [7:0] key_slot_0,
	input  logic [7:0] key_slot_1,
	input  logic [7:0] key_slot_2,
	input  logic [7:0] key_slot_3,
	input  logic [7:0] key_slot_4,
	input  logic [7:0] key_slot_5,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [1:0] event_kind,
	output logic [7:0] key_code,
	output logic [3:0] modifier_flags,
	output logic       last_event,
	input  logic       cfg_we,
	input  logic       cfg_index,
	input  logic [15:0] cfg_data
);

	localparam int EV_N = 2 * KEY_SLOTS;

	logic [hkd_pkg::CFG_W-1:0]                delay_q;
	logic [hkd_pkg::CFG_W-1:0]                interval_q;
	logic [KEY_SLOTS-1:0][hkd_pkg::KEY_W-1:0] prev_q;
	logic                                     caps_seen_q;
	logic                                     caps_q;
	logic [hkd_pkg::KEY_W-1:0]                held_key_q;
	logic [hkd_pkg::FLAG_W-1:0]               held_flags_q;
	logic [31:0]                              now_q;
	logic [31:0]                              held_since_q;
	logic [31:0]                              last_rep_q;

	logic [hkd_pkg::IN_SLOTS-1:0][hkd_pkg::KEY_W-1:0] in_slots;
	logic [KEY_SLOTS-1:0][hkd_pkg::KEY_W-1:0]         cur;
	hkd_pkg::lane_hit_t [KEY_SLOTS-1:0]               hits;
	logic [EV_N-1:0]                                  ev;
	logic [EV_N-1:0][hkd_pkg::KEY_W-1:0]              ev_codes;
	logic [EV_N-1:0][hkd_pkg::KEY_W-1:0]              load_codes;

	logic                        acc;
	logic                        is_tick;
	logic                        caps_now;
	logic                        caps_next;
	logic [hkd_pkg::FLAG_W-1:0]  flags;
	logic [hkd_pkg::KEY_W-1:0]   hk_next;
	logic [hkd_pkg::FLAG_W-1:0]  hf_next;
	logic                        any_down;
	logic [31:0]                 now_inc;
	logic                        rep_fire;
	logic                        load;
	logic                        can_load;

	assign in_slots = {key_slot_5, key_slot_4, key_slot_3, key_slot_2, key_slot_1, key_slot_0};

	// Slots past the six report fields read as empty.
	generate
		for (genvar g = 0; g < KEY_SLOTS; g++) begin : g_slot
			if (g < hkd_pkg::IN_SLOTS) begin : g_in
				assign cur[g] = in_slots[g];
			end else begin : g_empty
				assign cur[g] = '0;
			end

			hkd_lane #(.KEY_SLOTS(KEY_SLOTS)) u_lane (
				.cur_code  (cur[g]),
				.prev_code (prev_q[g]),
				.cur_keys  (cur),
				.prev_keys (prev_q),
				.hit       (hits[g])
			);

			assign ev[2*g]         = hits[g].down;
			assign ev[2*g+1]       = hits[g].up;
			assign ev_codes[2*g]   = cur[g];
			assign ev_codes[2*g+1] = prev_q[g];
		end
	endgenerate

	assign is_tick = (mode == hkd_pkg::MODE_TICK);
	assign acc     = in_valid && in_ready;

	always_comb begin
		caps_now = 1'b0;
		for (int i = 0; i < KEY_SLOTS; i++) begin
			if (cur[i] == hkd_pkg::CAPS_CODE) caps_now = 1'b1;
		end
		caps_next = caps_q ^ (caps_now && !caps_seen_q);
		flags = {caps_next,
			modifier_byte[0] | modifier_byte[4],
			modifier_byte[6],
			modifier_byte[1] | modifier_byte[5]};
	end

	// Merge: the last event in slot order decides the held key.
	always_comb begin
		hk_next  = held_key_q;
		hf_next  = held_flags_q;
		any_down = 1'b0;
		for (int i = 0; i < KEY_SLOTS; i++) begin
			if (hits[i].down) begin
				hk_next  = cur[i];
				hf_next  = flags;
				any_down = 1'b1;
			end
			if (hits[i].up) begin
				hk_next = '0;
				hf_next = '0;
			end
		end
	end

	always_comb begin
		now_inc  = now_q + 32'd1;
		rep_fire = (held_key_q != '0)
			&& ((now_inc - held_since_q) >= {16'd0, delay_q})
			&& ((now_inc - last_rep_q) > {16'd0, interval_q});
	end

	always_comb begin
		for (int j = 0; j < EV_N; j++) begin
			load_codes[j] = is_tick ? held_key_q : ev_codes[j];
		end
	end

	assign load = acc && (is_tick ? rep_fire : (|ev));

	hkd_emit #(.KEY_SLOTS(KEY_SLOTS)) u_emit (
		.clk         (clk),
		.arst_n      (arst_n),
		.load        (load),
		.load_ev     (is_tick ? EV_N'(1) : ev),
		.load_codes  (load_codes),
		.load_flags  (is_tick ? held_flags_q : flags),
		.load_repeat (is_tick),
		.can_load    (can_load),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.out_kind    (event_kind),
		.out_code    (key_code),
		.out_flags   (modifier_flags),
		.out_last    (last_event)
	);

	assign in_ready = can_load;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			delay_q    <= hkd_pkg::RST_DELAY;
			interval_q <= hkd_pkg::RST_INTERVAL;
		end else if (cfg_we) begin
			unique case (hkd_pkg::cfg_reg_t'(cfg_index))
				hkd_pkg::CFG_START_DELAY: delay_q    <= cfg_data;
				hkd_pkg::CFG_INTERVAL:    interval_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q       <= '0;
			caps_seen_q  <= 1'b0;
			caps_q       <= 1'b0;
			held_key_q   <= '0;
			held_flags_q <= '0;
			now_q        <= '0;
			held_since_q <= '0;
			last_rep_q   <= '0;
		end else if (acc) begin
			if (is_tick) begin
				now_q <= now_inc;
				if (rep_fire) last_rep_q <= now_inc;
			end else begin
				prev_q       <= cur;
				caps_seen_q  <= caps_now;
				caps_q       <= caps_next;
				held_key_q   <= hk_next;
				held_flags_q <= hf_next;
				if (any_down) begin
					held_since_q <= now_q;
					last_rep_q   <= '0;
				end
			end
		end
	end

	`HKD_ASSERT(a_caps_on_report, (caps_q == $past(caps_q)) || $past(acc && !is_tick), "caps lock moved without a report")
	`HKD_ASSERT(a_held_flags_clear, (held_key_q != '0) || (held_flags_q == '0), "stray held flags")
	`HKD_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(key_code), "beat dropped")

endmodule

`default_nettype wire

// ===== tb/hid_keyboard_report_event_differ_unit_tb.sv =====
// Self-checking bench for the keyboard report event differ: directed rows, then random phases.
// Predicts down, up and repeat beats from its own key and timing state; needs hkd_pkg and the RTL.
module hid_keyboard_report_event_differ_unit_tb;

	localparam int LIMIT_CYCLES    = 300000;
	localparam int SETTLE_CYCLES   = 24;
	localparam int PRESSURE_CYCLES = 300;
	localparam int PHASES          = 5;

	typedef struct packed {
		logic               mode;
		logic [7:0]         mods;
		logic [0:5][7:0]    slots;
	} kb_item_t;

	typedef struct packed {
		hkd_pkg::event_kind_t kind;
		logic [7:0]           code;
		logic [3:0]           flags;
		logic                 last;
	} key_evt_t;

	typedef enum logic {
		ROW_ITEM,
		ROW_CFG
	} row_op_t;

	typedef struct {
		row_op_t              op;
		logic                 mode;
		logic [7:0]           mods;
		logic [47:0]          slots;
		hkd_pkg::cfg_reg_t    reg_sel;
		logic [15:0]          val;
		int                   n_typed;
		hkd_pkg::event_kind_t ek;
		logic [7:0]           ec;
		logic [3:0]           ef;
	} stim_row_t;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic        mode;
	logic [7:0]  modifier_byte;
	logic [7:0]  key_slot_0, key_slot_1, key_slot_2, key_slot_3, key_slot_4, key_slot_5;
	logic        out_valid;
	logic        out_ready;
	logic [1:0]  event_kind;
	logic [7:0]  key_code;
	logic [3:0]  modifier_flags;
	logic        last_event;
	logic        cfg_we;
	logic        cfg_index;
	logic [15:0] cfg_data;

	hid_keyboard_report_event_differ_unit DUT (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.mode(mode), .modifier_byte(modifier_byte),
		.key_slot_0(key_slot_0), .key_slot_1(key_slot_1), .key_slot_2(key_slot_2),
		.key_slot_3(key_slot_3), .key_slot_4(key_slot_4), .key_slot_5(key_slot_5),
		.out_valid(out_valid), .out_ready(out_ready),
		.event_kind(event_kind), .key_code(key_code),
		.modifier_flags(modifier_flags), .last_event(last_event),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	// key and timing state of the predictor
	logic [0:5][7:0] prev_keys;
	logic            caps_seen;
	logic            caps_on;
	logic [7:0]      held_key;
	logic [3:0]      held_flags;
	logic [31:0]     now_ms;
	logic [31:0]     held_since;
	logic [31:0]     last_rep;
	logic [15:0]     rpt_delay;
	logic [15:0]     rpt_interval;

	key_evt_t fresh_events[$];
	key_evt_t pending_events[$];

	// typed expectation of the item now on the input
	int          cur_n_typed;
	key_evt_t    cur_typed;

	int send_idle_pct;
	int recv_stall_pct;
	bit pressure_go;
	bit hold_off;
	int errors;
	int cycle_count;
	int beats_in;
	int beats_out;
	int repeats_out;

	logic [0:5][7:0] typing_slots;
	stim_row_t       rows [0:23];
	int ph_delay    [0:PHASES-1] = '{3, 0, 10, -1, 1};
	int ph_interval [0:PHASES-1] = '{1, 0, 5, -1, 2};
	int ph_send     [0:PHASES-1] = '{0, 84, 0, 10, 0};
	int ph_recv     [0:PHASES-1] = '{0, 0, 84, 10, 0};
	int ph_items    [0:PHASES-1] = '{40, 35, 35, 35, 35};

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic bit holds_code(input logic [0:5][7:0] keys, input logic [7:0] code);
		for (int i = 0; i < hkd_pkg::IN_SLOTS; i++)
			if (keys[i] == code)
				return 1'b1;
		return 1'b0;
	endfunction

	function void add_event(input hkd_pkg::event_kind_t k, input logic [7:0] c,
			input logic [3:0] f);
		key_evt_t ev;
		ev.kind = k;
		ev.code = c;
		ev.flags = f;
		ev.last = 1'b0;
		// drop anything past the per-item cap; state effects still apply
		if (fresh_events.size() < hkd_pkg::MAX_EVENTS)
			fresh_events.push_back(ev);
	endfunction

	function void derive_key_events(input kb_item_t it);
		logic [3:0] fl;
		bit         caps_now;
		key_evt_t   tail;
		fresh_events.delete();
		if (it.mode == hkd_pkg::MODE_TICK) begin
			now_ms = now_ms + 32'd1;
			if (held_key != 8'd0 && (now_ms - held_since) >= {16'd0, rpt_delay} &&
					(now_ms - last_rep) > {16'd0, rpt_interval}) begin
				last_rep = now_ms;
				add_event(hkd_pkg::EV_REPEAT, held_key, held_flags);
			end
		end else begin
			caps_now = holds_code(it.slots, hkd_pkg::CAPS_CODE);
			if (caps_now && !caps_seen)
				caps_on = !caps_on;
			caps_seen = caps_now;
			fl = {caps_on, |(it.mods & 8'h11), it.mods[6], |(it.mods & 8'h22)};
			for (int i = 0; i < hkd_pkg::IN_SLOTS; i++) begin
				if (it.slots[i] != 8'd0 && !holds_code(prev_keys, it.slots[i])) begin
					held_key = it.slots[i];
					held_flags = fl;
					held_since = now_ms;
					last_rep = 32'd0;
					add_event(hkd_pkg::EV_DOWN, it.slots[i], fl);
				end
				if (prev_keys[i] != 8'd0 && !holds_code(it.slots, prev_keys[i])) begin
					held_key = 8'd0;
					held_flags = 4'd0;
					add_event(hkd_pkg::EV_UP, prev_keys[i], fl);
				end
			end
			prev_keys = it.slots;
		end
		if (fresh_events.size() > 0) begin
			tail = fresh_events[fresh_events.size() - 1];
			tail.last = 1'b1;
			fresh_events[fresh_events.size() - 1] = tail;
		end
	endfunction

	task report_mismatch(input string field, input int got, input int want);
		$display("mismatch at result beat %0d, %s: got %0h want %0h", beats_out, field, got, want);
		errors++;
	endtask

	// sample every handshake at the rising edge: config, input beat, result beat
	always @(posedge clk) begin
		kb_item_t it;
		key_evt_t want;
		if (arst_n) begin
			if (cfg_we) begin
				if (hkd_pkg::cfg_reg_t'(cfg_index) == hkd_pkg::CFG_START_DELAY)
					rpt_delay = cfg_data;
				else
					rpt_interval = cfg_data;
			end
			if (in_valid && in_ready) begin
				it.mode = mode;
				it.mods = modifier_byte;
				it.slots = {key_slot_0, key_slot_1, key_slot_2, key_slot_3, key_slot_4, key_slot_5};
				derive_key_events(it);
				beats_in++;
				if (cur_n_typed >= 0) begin
					if (cur_n_typed > 0)
						pending_events.push_back(cur_typed);
				end else begin
					foreach (fresh_events[i])
						pending_events.push_back(fresh_events[i]);
				end
			end
			if (out_valid && out_ready) begin
				beats_out++;
				if (pending_events.size() == 0) begin
					report_mismatch("unexpected beat, key", int'(key_code), 0);
				end else begin
					want = pending_events.pop_front();
					if (event_kind !== want.kind)
						report_mismatch("event_kind", int'(event_kind), int'(want.kind));
					if (key_code !== want.code)
						report_mismatch("key_code", int'(key_code), int'(want.code));
					if (modifier_flags !== want.flags)
						report_mismatch("modifier_flags", int'(modifier_flags),
							int'(want.flags));
					if (last_event !== want.last)
						report_mismatch("last_event", int'(last_event), int'(want.last));
					if (want.kind == hkd_pkg::EV_REPEAT)
						repeats_out++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= LIMIT_CYCLES) begin
			$display("timeout after %0d cycles, %0d results still due", cycle_count,
				pending_events.size());
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	// long receiver hold-off, counted here so the sender keeps offering
	always begin
		wait (pressure_go);
		hold_off = 1'b1;
		repeat (PRESSURE_CYCLES) @(posedge clk);
		hold_off = 1'b0;
		pressure_go = 1'b0;
	end

	always @(negedge clk)
		out_ready <= !hold_off && ($urandom_range(99) >= recv_stall_pct);

	task push_item(input kb_item_t it, input int n_typed, input key_evt_t typed);
		@(negedge clk);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		cur_n_typed = n_typed;
		cur_typed = typed;
		in_valid <= 1'b1;
		mode <= it.mode;
		modifier_byte <= it.mods;
		key_slot_0 <= it.slots[0];
		key_slot_1 <= it.slots[1];
		key_slot_2 <= it.slots[2];
		key_slot_3 <= it.slots[3];
		key_slot_4 <= it.slots[4];
		key_slot_5 <= it.slots[5];
		do
			@(posedge clk);
		while (!in_ready);
	endtask

	// drain expected beats, then give a no-result item time to leave the block
	task settle;
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending_events.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task write_reg(input hkd_pkg::cfg_reg_t sel, input logic [15:0] val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= sel;
		cfg_data <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// mostly evolve the last report over a small key pool; sometimes pure noise or a tick
	function kb_item_t roll_item();
		kb_item_t it;
		int pick;
		pick = $urandom_range(99);
		it.mods = 8'($urandom_range(255));
		it.mode = (pick < 35) ? hkd_pkg::MODE_TICK : ~hkd_pkg::MODE_TICK;
		for (int i = 0; i < hkd_pkg::IN_SLOTS; i++) begin
			if (pick >= 35 && pick < 45) begin
				it.slots[i] = 8'($urandom_range(255));
			end else if ($urandom_range(99) < 30) begin
				if ($urandom_range(1) == 0)
					it.slots[i] = 8'd0;
				else if ($urandom_range(9) == 0)
					it.slots[i] = hkd_pkg::CAPS_CODE;
				else
					it.slots[i] = 8'($urandom_range(10, 4));
			end else begin
				it.slots[i] = typing_slots[i];
			end
		end
		if (it.mode != hkd_pkg::MODE_TICK)
			typing_slots = it.slots;
		return it;
	endfunction

	initial begin
		kb_item_t  it;
		key_evt_t  typed;
		int        dly;
		int        ivl;

		arst_n = 1'b0;
		in_valid = 1'b0;
		out_ready = 1'b0;
		mode = 1'b0;
		modifier_byte = 8'd0;
		key_slot_0 = 8'd0;
		key_slot_1 = 8'd0;
		key_slot_2 = 8'd0;
		key_slot_3 = 8'd0;
		key_slot_4 = 8'd0;
		key_slot_5 = 8'd0;
		cfg_we = 1'b0;
		cfg_index = hkd_pkg::CFG_START_DELAY;
		cfg_data = 16'd0;
		clk = 1'b0;
		prev_keys = '0;
		caps_seen = 1'b0;
		caps_on = 1'b0;
		held_key = 8'd0;
		held_flags = 4'd0;
		now_ms = 32'd0;
		held_since = 32'd0;
		last_rep = 32'd0;
		rpt_delay = hkd_pkg::RST_DELAY;
		rpt_interval = hkd_pkg::RST_INTERVAL;
		typing_slots = '0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		pressure_go = 1'b0;
		hold_off = 1'b0;
		errors = 0;
		cycle_count = 0;
		beats_in = 0;
		beats_out = 0;
		repeats_out = 0;
		cur_n_typed = -1;
		cur_typed = '0;

		// n_typed: -1 predicted, 0 no result, 1 the single beat typed here
		rows[0]  = '{ROW_ITEM, 1'b0, 8'h00, 48'h04_00_00_00_00_00, hkd_pkg::CFG_START_DELAY,
			16'd0, 1, hkd_pkg::EV_DOWN, 8'h04, 4'h0};
		rows[1]  = '{ROW_ITEM, 1'b0, 8'h00, 48'h0, hkd_pkg::CFG_START_DELAY, 16'd0,
			1, hkd_pkg::EV_UP, 8'h04, 4'h0};
		rows[2]  = '{ROW_ITEM, 1'b0, 8'h00, 48'h0, hkd_pkg::CFG_START_DELAY, 16'd0,
			0, hkd_pkg::EV_DOWN, 8'h0, 4'h0};
		rows[3]  = '{ROW_ITEM, 1'b1, 8'h00, 48'h0, hkd_pkg::CFG_START_DELAY, 16'd0,
			0, hkd_pkg::EV_DOWN, 8'h0, 4'h0};
		rows[4]  = '{ROW_ITEM, 1'b0, 8'hFF, 48'h39_00_00_00_00_00, hkd_pkg::CFG_START_DELAY,
			16'd0, 1, hkd_pkg::EV_DOWN, 8'h39, 4'hF};
		rows[5]  = '{ROW_ITEM, 1'b0, 8'h00, 48'h0, hkd_pkg::CFG_START_DELAY, 16'd0,
			1, hkd_pkg::EV_UP, 8'h39, 4'h8};
		rows[6]  = '{ROW_ITEM, 1'b0, 8'h22, 48'h39_00_00_00_00_00, hkd_pkg::CFG_START_DELAY,
			16'd0, 1, hkd_pkg::EV_DOWN, 8'h39, 4'h1};
		rows[7]  = '{ROW_ITEM, 1'b0, 8'h00, 48'h0, hkd_pkg::CFG_START_DELAY, 16'd0,
			1, hkd_pkg::EV_UP, 8'h39, 4'h0};
		rows[8]  = '{ROW_ITEM, 1'b0, 8'h40, 48'hFF_FE_FD_FC_FB_FA, hkd_pkg::CFG_START_DELAY,
			16'd0, -1, hkd_pkg::EV_DOWN, 8'h0, 4'h0};
		rows[9]  = '{ROW_ITEM, 1'b0, 8'h11, 48'h01_02_03_04_05_06, hkd_pkg::CFG_START_DELAY,
			16'd0, -1, hkd_pkg::EV_DOWN, 8'h0, 4'h0};
		rows[10] = '{ROW_ITEM, 1'b0, 8'h80, 48'h07_07_07_00_00_00, hkd_pkg::CFG_START_DELAY,
			16'd0, -1, hkd_pkg::EV_DOWN, 8'h0, 4'h0};
		rows[11] = '{ROW_ITEM, 1'b0, 8'h0C, 48'h00_00_00_07_07_00, hkd_pkg::CFG_START_DELAY,
			16'd0, -1, hkd_pkg::EV_DOWN, 8'h0, 4'h0};
		rows[12] = '{ROW_ITEM, 1'b0, 8'h00, 48'h0, hkd_pkg::CFG_START_DELAY, 16'd0,
			-1, hkd_pkg::EV_DOWN, 8'h0, 4'h0};
		rows[13] = '{ROW_CFG, 1'b0, 8'h00, 48'h0, hkd_pkg::CFG_START_DELAY, 16'd0,
			0, hkd_pkg::EV_DOWN, 8'h0, 4'h0};
		rows[14] = '{ROW_CFG, 1'b0, 8'h00, 48'h0, hkd_pkg::CFG_INTERVAL, 16'd0,
			0, hkd_pkg::EV_DOWN, 8'h0, 4'h0};
		rows[15] = '{ROW_ITEM, 1'b0, 8'h02, 48'h2A_00_00_00_00_00, hkd_pkg::CFG_START_DELAY,
			16'd0, 1, hkd_pkg::EV_DOWN, 8'h2A, 4'h1};
		rows[16] = '{ROW_ITEM, 1'b1, 8'h00, 48'h0, hkd_pkg::CFG_START_DELAY, 16'd0,
			-1, hkd_pkg::EV_DOWN, 8'h0, 4'h0};
		rows[17] = '{ROW_ITEM, 1'b1, 8'h00, 48'h0, hkd_pkg::CFG_START_DELAY, 16'd0,
			-1, hkd_pkg::EV_DOWN, 8'h0, 4'h0};
		rows[18] = '{ROW_CFG, 1'b0, 8'h00, 48'h0, hkd_pkg::CFG_START_DELAY, 16'hFFFF,
			0, hkd_pkg::EV_DOWN, 8'h0, 4'h0};
		rows[19] = '{ROW_CFG, 1'b0, 8'h00, 48'h0, hkd_pkg::CFG_INTERVAL, 16'hFFFF,
			0, hkd_pkg::EV_DOWN, 8'h0, 4'h0};
		rows[20] = '{ROW_ITEM, 1'b1, 8'h00, 48'h0, hkd_pkg::CFG_START_DELAY, 16'd0,
			0, hkd_pkg::EV_DOWN, 8'h0, 4'h0};
		rows[21] = '{ROW_ITEM, 1'b0, 8'h33, 48'h39_2A_00_00_00_00, hkd_pkg::CFG_START_DELAY,
			16'd0, 1, hkd_pkg::EV_DOWN, 8'h39, 4'hD};
		rows[22] = '{ROW_ITEM, 1'b0, 8'h00, 48'h0, hkd_pkg::CFG_START_DELAY, 16'd0,
			-1, hkd_pkg::EV_DOWN, 8'h0, 4'h0};
		rows[23] = '{ROW_ITEM, 1'b1, 8'h00, 48'h0, hkd_pkg::CFG_START_DELAY, 16'd0,
			0, hkd_pkg::EV_DOWN, 8'h0, 4'h0};

		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		foreach (rows[r]) begin
			if (rows[r].op == ROW_CFG) begin
				settle();
				write_reg(rows[r].reg_sel, rows[r].val);
			end else begin
				it.mode = rows[r].mode;
				it.mods = rows[r].mods;
				it.slots = rows[r].slots;
				typed.kind = rows[r].ek;
				typed.code = rows[r].ec;
				typed.flags = rows[r].ef;
				typed.last = 1'b1;
				push_item(it, rows[r].n_typed, typed);
			end
		end

		typed = '0;
		for (int p = 0; p < PHASES; p++) begin
			settle();
			dly = (ph_delay[p] < 0) ? $urandom_range(6) : ph_delay[p];
			ivl = (ph_interval[p] < 0) ? $urandom_range(3) : ph_interval[p];
			write_reg(hkd_pkg::CFG_START_DELAY, 16'(dly));
			write_reg(hkd_pkg::CFG_INTERVAL, 16'(ivl));
			send_idle_pct = ph_send[p];
			recv_stall_pct = ph_recv[p];
			if (p == PHASES - 1)
				pressure_go = 1'b1;
			for (int n = 0; n < ph_items[p]; n++)
				push_item(roll_item(), -1, typed);
		end

		settle();
		$display("covered %0d input beats and %0d result beats, %0d of them repeats", beats_in,
			beats_out, repeats_out);
		$display("directed corners, then five random phases with gaps, stalls and a long hold-off");
		if (errors == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
